[design/kdv_pkg.sv]
// Shared types, constants and a helper function for the kick drum voice.
package kdv_pkg;

    localparam int PHASE_BITS = 24;
    localparam int ENV_BITS   = 24;
    localparam int W_BITS     = 32;
    localparam int CFG_BITS   = 24;
    localparam int IDX_BITS   = 3;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_BITS-1:0] {
        REG_PEAK_INC   = 3'd0,
        REG_BASE_INC   = 3'd1,
        REG_AMP_RATIO  = 3'd2,
        REG_PITCH_RAT  = 3'd3,
        REG_FOLD_AMT   = 3'd4,
        REG_SQUARE_AMT = 3'd5,
        REG_FOLD_PASS  = 3'd6
    } reg_idx_t;

    localparam logic [ENV_BITS-1:0] ENV_FULL  = 24'hFFFFFF;
    localparam logic [16:0]         UNITY_Q16 = 17'd65536;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INC,
        ST_PHASE,
        ST_SIN0,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_SIN4,
        ST_SIN5,
        ST_FGAIN,
        ST_FAPPLY,
        ST_REFL,
        ST_SGAIN,
        ST_SAPPLY,
        ST_AMP,
        ST_PITCH,
        ST_DRUM,
        ST_DRUM1,
        ST_DRUM2,
        ST_FIN,
        ST_DONE
    } state_t;

    // Configuration as seen by the datapath, already clamped.
    typedef struct packed {
        logic [22:0] peak_inc;
        logic [22:0] base_inc;
        logic [23:0] amp_ratio;
        logic [23:0] pitch_ratio;
        logic [18:0] fold_gain;
        logic [18:0] square_gain;
        logic [2:0]  passes;
    } cfg_t;

    // Floor of x / (2^24 - 1), valid for x below 2^48 - 2^24.
    function automatic logic [23:0] div_ffffff(input logic [47:0] x);
        logic [48:0] sum;
        sum = {1'b0, x} + {25'd0, x[47:24]} + 49'd1;
        return sum[47:24];
    endfunction

endpackage

[design/kdv_if.sv]
// Valid/ready channel interfaces for the input samples and the results.
interface kdv_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] trigger_level;
    logic signed [15:0] sound_level;

    modport source (output valid, output trigger_level, output sound_level, input ready);
    modport sink   (input valid, input trigger_level, input sound_level, output ready);
endinterface

interface kdv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drum_sample;
    logic        [15:0] amp_level;
    logic        [15:0] pitch_level;
    logic signed [15:0] folded_sound;

    modport source (output valid, output drum_sample, output amp_level,
                    output pitch_level, output folded_sound, input ready);
    modport sink   (input valid, input drum_sample, input amp_level,
                    input pitch_level, input folded_sound, output ready);
endinterface

[design/kick_drum_voice_with_wavefolder.sv]
// Top level of the kick drum voice: sequencer and datapath around one multiplier.
//
// Each input beat is one audio sample. A Schmitt trigger restarts the voice, a
// phase accumulator driven by the pitch envelope reads a polynomial sine, and
// both the sine and the external sound pass through a wavefolder before the
// envelopes decay. All multiplications run through a single shared 32x32
// multiplier under a small sequencer, and the number of fold passes actually run
// for the sine and for the sound is 1 to 5 each. The input is not ready while a
// sample is in work; a finished result waits in the output register until taken,
// and the next one waits in the sequencer until that register is free.
module kick_drum_voice_with_wavefolder (
    input  logic             clk,
    input  logic             rst_n,
    kdv_in_if.sink           in_ch,
    kdv_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [kdv_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [kdv_pkg::CFG_BITS-1:0] cfg_data
);
    import kdv_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [ENV_BITS-1:0]   amp_reg, amp_next, pitch_reg, pitch_next;
    logic                  trig_reg, trig_next;
    logic signed [15:0]    snd_reg, snd_next;
    logic signed [W_BITS-1:0] w_reg, w_next;
    logic [2:0]  pass_reg, pass_next;
    logic        flag_reg, flag_next;
    logic [1:0]  refl_reg, refl_next;
    logic        which_reg, which_next;
    logic [15:0] z_reg, z_next, z2_reg, z2_next;
    logic [16:0] sin_mag_reg, sin_mag_next, snd_mag_reg, snd_mag_next;
    logic        sin_neg_reg, sin_neg_next, snd_neg_reg, snd_neg_next;
    logic [39:0] y_reg, y_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [15:0] drum_reg, drum_next, fsnd_reg, fsnd_next;
    logic [15:0] ampl_reg, ampl_next, pitl_reg, pitl_next;
    logic signed [15:0] drum_res_reg, drum_res_next, fsnd_res_reg, fsnd_res_next;
    logic [15:0] ampl_res_reg, ampl_res_next, pitl_res_reg, pitl_res_next;

    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    logic signed [23:0] diff;
    logic [22:0] diff_mag, dm;
    logic [7:0]  sidx;
    logic [14:0] u;
    logic [16:0] poly;
    logic [31:0] mag, w_abs, s_mag;
    logic signed [W_BITS-1:0] w1, w2;
    logic        refl1, refl2;
    logic [55:0] k_sh;
    logic [15:0] dres, fres;
    logic [31:0] fsh;

    kdv_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    kdv_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (prod)
    );

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            amp_reg       <= ENV_FULL;
            pitch_reg     <= '0;
            trig_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            amp_reg       <= amp_next;
            pitch_reg     <= pitch_next;
            trig_reg      <= trig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snd_reg      <= snd_next;
        w_reg        <= w_next;
        pass_reg     <= pass_next;
        flag_reg     <= flag_next;
        refl_reg     <= refl_next;
        which_reg    <= which_next;
        z_reg        <= z_next;
        z2_reg       <= z2_next;
        sin_mag_reg  <= sin_mag_next;
        sin_neg_reg  <= sin_neg_next;
        snd_mag_reg  <= snd_mag_next;
        snd_neg_reg  <= snd_neg_next;
        y_reg        <= y_next;
        drum_reg     <= drum_next;
        fsnd_reg     <= fsnd_next;
        ampl_reg     <= ampl_next;
        pitl_reg     <= pitl_next;
        drum_res_reg <= drum_res_next;
        fsnd_res_reg <= fsnd_res_next;
        ampl_res_reg <= ampl_res_next;
        pitl_res_reg <= pitl_res_next;
    end

    // Combinational helper values used by the sequencer steps.
    always_comb
    begin
        diff     = $signed({1'b0, cfg.peak_inc}) - $signed({1'b0, cfg.base_inc});
        diff_mag = diff[23] ? 23'(-diff) : diff[22:0];
        dm       = prod[46:24];
        sidx     = phase_reg[PHASE_BITS-1 -: 8];
        u        = {1'b0, sidx[5:0], 8'd0};
        if (sidx[6])
            u = 15'd16384 - u;
        mag      = prod[47:16];
        s_mag    = prod[46:15];
        w_abs    = w_reg[W_BITS-1] ? 32'(-w_reg) : 32'(w_reg);
        // One reflect iteration: upper bound first, then lower bound.
        refl1    = (w_reg > 32'sd65536);
        w1       = refl1 ? (32'sd131072 - w_reg) : w_reg;
        refl2    = (w1 < -32'sd65536);
        w2       = refl2 ? (-32'sd131072 - w1) : w1;
        k_sh     = ({15'd0, prod[40:0]} << 15) - {15'd0, prod[40:0]};
        dres     = 16'(div_ffffff({8'd0, y_reg}));
        fsh      = (({15'd0, snd_mag_reg} << 15) - {15'd0, snd_mag_reg}) >> 16;
        fres     = fsh[15:0];
    end

    // Sequencer: next state, multiplier operands and register updates.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        amp_next       = amp_reg;
        pitch_next     = pitch_reg;
        trig_next      = trig_reg;
        snd_next       = snd_reg;
        w_next         = w_reg;
        pass_next      = pass_reg;
        flag_next      = flag_reg;
        refl_next      = refl_reg;
        which_next     = which_reg;
        z_next         = z_reg;
        z2_next        = z2_reg;
        sin_mag_next   = sin_mag_reg;
        sin_neg_next   = sin_neg_reg;
        snd_mag_next   = snd_mag_reg;
        snd_neg_next   = snd_neg_reg;
        y_next         = y_reg;
        drum_next      = drum_reg;
        fsnd_next      = fsnd_reg;
        ampl_next      = ampl_reg;
        pitl_next      = pitl_reg;
        drum_res_next  = drum_res_reg;
        fsnd_res_next  = fsnd_res_reg;
        ampl_res_next  = ampl_res_reg;
        pitl_res_next  = pitl_res_reg;
        out_valid_next = out_valid_reg;
        poly           = 17'd0;
        op_a           = '0;
        op_b           = '0;
        in_ch.ready    = 1'b0;

        // The consumer taking the held result empties the output register.
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    snd_next = in_ch.sound_level;
                    if (trig_reg)
                    begin
                        if (in_ch.trigger_level <= 16'sd0)
                            trig_next = 1'b0;
                    end
                    else if (in_ch.trigger_level >= 16'sd2048)
                    begin
                        trig_next  = 1'b1;
                        phase_next = '0;
                        amp_next   = ENV_FULL;
                        pitch_next = ENV_FULL;
                    end
                    state_next = ST_INC;
                end
            end
            ST_INC:
            begin
                op_a       = {8'd0, pitch_reg};
                op_b       = {9'd0, diff_mag};
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                phase_next = phase_reg + {1'b0, cfg.base_inc}
                             + (diff[23] ? 24'(-{1'b0, dm}) : {1'b0, dm});
                state_next = ST_SIN0;
            end
            ST_SIN0:
            begin
                z_next     = {u, 1'b0};
                op_a       = {16'd0, u, 1'b0};
                op_b       = {16'd0, u, 1'b0};
                state_next = ST_SIN1;
            end
            ST_SIN1:
            begin
                z2_next    = prod[30:15];
                op_a       = 32'd307;
                op_b       = {16'd0, prod[30:15]};
                state_next = ST_SIN2;
            end
            ST_SIN2:
            begin
                poly       = 17'd5223 - prod[31:15];
                op_a       = {15'd0, poly};
                op_b       = {16'd0, z2_reg};
                state_next = ST_SIN3;
            end
            ST_SIN3:
            begin
                poly       = 17'd42334 - prod[31:15];
                op_a       = {15'd0, poly};
                op_b       = {16'd0, z2_reg};
                state_next = ST_SIN4;
            end
            ST_SIN4:
            begin
                poly       = 17'd102944 - prod[31:15];
                op_a       = {15'd0, poly};
                op_b       = {16'd0, z_reg};
                state_next = ST_SIN5;
            end
            ST_SIN5:
            begin
                if (s_mag > 32'd65536)
                    w_next = 32'sd65536;
                else
                    w_next = $signed(s_mag);
                if (sidx[7])
                    w_next = -w_next;
                which_next = 1'b0;
                pass_next  = cfg.passes;
                state_next = ST_FGAIN;
            end
            ST_FGAIN:
            begin
                op_a       = w_abs;
                op_b       = {13'd0, cfg.fold_gain};
                pass_next  = pass_reg - 3'd1;
                flag_next  = 1'b0;
                state_next = ST_FAPPLY;
            end
            ST_FAPPLY:
            begin
                w_next     = w_reg[W_BITS-1] ? -$signed(mag) : $signed(mag);
                refl_next  = 2'd0;
                state_next = ST_REFL;
            end
            ST_REFL:
            begin
                w_next    = w2;
                flag_next = flag_reg | refl1 | refl2;
                refl_next = refl_reg + 2'd1;
                if (refl_reg == 2'd2)
                begin
                    if ((pass_reg != 3'd0) && (flag_reg | refl1 | refl2))
                        state_next = ST_FGAIN;
                    else
                        state_next = ST_SGAIN;
                end
            end
            ST_SGAIN:
            begin
                op_a       = w_abs;
                op_b       = {13'd0, cfg.square_gain};
                state_next = ST_SAPPLY;
            end
            ST_SAPPLY:
            begin
                if (which_reg == 1'b0)
                begin
                    sin_mag_next = (mag > 32'd65536) ? UNITY_Q16 : mag[16:0];
                    sin_neg_next = w_reg[W_BITS-1];
                    w_next       = {{12{snd_reg[15]}}, snd_reg, 4'd0};
                    which_next   = 1'b1;
                    pass_next    = cfg.passes;
                    state_next   = ST_FGAIN;
                end
                else
                begin
                    snd_mag_next = (mag > 32'd65536) ? UNITY_Q16 : mag[16:0];
                    snd_neg_next = w_reg[W_BITS-1];
                    state_next   = ST_AMP;
                end
            end
            ST_AMP:
            begin
                op_a       = {8'd0, amp_reg};
                op_b       = {8'd0, cfg.amp_ratio};
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                amp_next   = prod[47:24];
                op_a       = {8'd0, pitch_reg};
                op_b       = {8'd0, cfg.pitch_ratio};
                state_next = ST_DRUM;
            end
            ST_DRUM:
            begin
                pitch_next = prod[47:24];
                state_next = ST_DRUM1;
            end
            ST_DRUM1:
            begin
                op_a       = {15'd0, sin_mag_reg};
                op_b       = {8'd0, amp_reg};
                state_next = ST_DRUM2;
            end
            ST_DRUM2:
            begin
                y_next     = k_sh[55:16];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                drum_next  = sin_neg_reg ? -$signed(dres) : $signed(dres);
                fsnd_next  = snd_neg_reg ? -$signed(fres) : $signed(fres);
                ampl_next  = 16'(div_ffffff(({24'd0, amp_reg} << 16) - {24'd0, amp_reg}));
                pitl_next  = 16'(div_ffffff(({24'd0, pitch_reg} << 16)
                                            - {24'd0, pitch_reg}));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    drum_res_next  = drum_reg;
                    fsnd_res_next  = fsnd_reg;
                    ampl_res_next  = ampl_reg;
                    pitl_res_next  = pitl_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output channel.
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.drum_sample  = drum_res_reg;
    assign out_ch.amp_level    = ampl_res_reg;
    assign out_ch.pitch_level  = pitl_res_reg;
    assign out_ch.folded_sound = fsnd_res_reg;
endmodule

[design/kdv_mul.sv]
// Shared 32 by 32 unsigned multiplier with a registered product.
module kdv_mul (
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);
    logic [63:0] product_reg;

    // The product is registered and read in the cycle after the operands are issued.
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;
endmodule

[design/kdv_cfg.sv]
// Configuration register file with clamping of the fold settings.
module kdv_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [kdv_pkg::IDX_BITS-1:0] index,
    input  logic [kdv_pkg::CFG_BITS-1:0] data,
    output kdv_pkg::cfg_t         cfg
);
    import kdv_pkg::*;

    logic [22:0] peak_reg, base_reg;
    logic [23:0] amp_ratio_reg, pitch_ratio_reg;
    logic [16:0] fold_reg, square_reg;
    logic [2:0]  passes_reg;
    logic [16:0] fold_c, square_c;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg        <= 23'd122333;
            base_reg        <= 23'd10486;
            amp_ratio_reg   <= 24'd16776251;
            pitch_ratio_reg <= 24'd16765679;
            fold_reg        <= 17'd32768;
            square_reg      <= 17'd13107;
            passes_reg      <= 3'd1;
        end
        else if (we)
        begin
            case (index)
                REG_PEAK_INC:   peak_reg        <= data[22:0];
                REG_BASE_INC:   base_reg        <= data[22:0];
                REG_AMP_RATIO:  amp_ratio_reg   <= data[23:0];
                REG_PITCH_RAT:  pitch_ratio_reg <= data[23:0];
                REG_FOLD_AMT:   fold_reg        <= data[16:0];
                REG_SQUARE_AMT: square_reg      <= data[16:0];
                REG_FOLD_PASS:  passes_reg      <= data[2:0];
                default:        ;
            endcase
        end
    end

    // Amounts saturate at one; pass count is held to one through five.
    always_comb
    begin
        fold_c   = (fold_reg > UNITY_Q16) ? UNITY_Q16 : fold_reg;
        square_c = (square_reg > UNITY_Q16) ? UNITY_Q16 : square_reg;
        cfg.peak_inc    = peak_reg;
        cfg.base_inc    = base_reg;
        cfg.amp_ratio   = amp_ratio_reg;
        cfg.pitch_ratio = pitch_ratio_reg;
        cfg.fold_gain   = 19'd65536 + {1'b0, fold_c, 1'b0};
        cfg.square_gain = 19'd65536 + {square_c, 2'b00};
        if (passes_reg == 3'd0)
            cfg.passes = 3'd1;
        else if (passes_reg > 3'd5)
            cfg.passes = 3'd5;
        else
            cfg.passes = passes_reg;
    end
endmodule
